/* rtl/abd_pkg.sv */
// ----------------------------------------------------------------------------
// Audio beat detector package
// Shared constants, types, filter coefficients and the sequencer program.
// ----------------------------------------------------------------------------
package abd_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int SAMPLE_BITS = 10;

  // Configuration port
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int THR_W     = 24;
  localparam int OFF_W     = 10;
  localparam int DEC_W     = 16;

  // Datapath
  localparam int DATA_W = 32;
  localparam int PROD_W = 64;
  localparam int CQ     = 30;               // coefficient fraction bits
  localparam int RND_W  = PROD_W - CQ;      // rounded product width
  localparam int ACC_W  = 42;               // holds the scaled input and every filter sum

  localparam int NUM_REGS = 13;
  localparam int STEP_W   = 5;
  localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_DONE  = STEP_W'(24);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_DC_OFFSET = 2'd1,
    CFG_DECIM     = 2'd2
  } cfg_idx_e;

  localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(52429);
  localparam logic [OFF_W-1:0] DC_OFFSET_RST = OFF_W'(120);
  localparam logic [DEC_W-1:0] DECIM_RST     = DEC_W'(200);

  // Register file entries: filter history, one scratch slot and two spares
  typedef enum logic [3:0] {
    R_XS    = 4'd0,
    R_BIN0  = 4'd1,
    R_BIN1  = 4'd2,
    R_BOUT0 = 4'd3,
    R_BOUT1 = 4'd4,
    R_EIN   = 4'd5,
    R_EOUT  = 4'd6,
    R_TIN0  = 4'd7,
    R_TIN1  = 4'd8,
    R_TOUT0 = 4'd9,
    R_TOUT1 = 4'd10,
    R_SPARE0 = 4'd11,
    R_SPARE1 = 4'd12
  } reg_e;

  typedef enum logic [2:0] {
    C_RBASS = 3'd0,
    C_BA2   = 3'd1,
    C_BA1   = 3'd2,
    C_RENV  = 3'd3,
    C_EA1   = 3'd4,
    C_RBEAT = 3'd5,
    C_TA2   = 3'd6,
    C_TA1   = 3'd7
  } coef_e;

  typedef enum logic [2:0] {
    A_NOP  = 3'd0,
    A_LDX  = 3'd1,   // load centered sample in Q format
    A_PROD = 3'd2,   // load saturated rounded product
    A_ADDP = 3'd3,   // add rounded product
    A_ADDR = 3'd4,   // add register read data
    A_SUBR = 3'd5,   // subtract register read data
    A_ABS  = 3'd6    // full-wave rectify
  } acc_op_e;

  typedef enum logic {
    MS_RD  = 1'b0,
    MS_ACC = 1'b1
  } mul_src_e;

  typedef enum logic {
    WS_ACC = 1'b0,
    WS_RD  = 1'b1
  } wr_src_e;

  typedef enum logic [2:0] {
    F_IDLE  = 3'd0,
    F_NEXT  = 3'd1,
    F_DECIM = 3'd2,
    F_FLAG  = 3'd3,
    F_DONE  = 3'd4
  } flow_e;

  typedef struct packed {
    logic     rd_en;
    reg_e     rd_addr;
    logic     mul_en;
    mul_src_e mul_src;
    coef_e    coef;
    acc_op_e  acc_op;
    logic     wr_en;
    wr_src_e  wr_src;
    reg_e     wr_dst;
    flow_e    flow;
  } ucode_t;

  function automatic logic signed [DATA_W-1:0] coef_value(input coef_e c);
    logic signed [DATA_W-1:0] v;
    case (c)
      C_RBASS: v = 32'sd117993607;
      C_BA2:   v = -32'sd854704936;
      C_BA1:   v = 32'sd1922333318;
      C_RENV:  v = 32'sd6710886;
      C_EA1:   v = 32'sd1060332861;
      C_RBEAT: v = 32'sd153063696;
      C_TA2:   v = -32'sd769858042;
      C_TA1:   v = 32'sd1551949227;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Clamp a wide sum to the signed 32-bit range.
  function automatic logic [DATA_W-1:0] sat32(input logic [ACC_W-1:0] v);
    logic [DATA_W-1:0] r;
    if ((&v[ACC_W-1:DATA_W-1]) || !(|v[ACC_W-1:DATA_W-1])) begin
      r = v[DATA_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Sequencer program. Operations in a step use the accumulator, product and
  // read data registered at the start of that step.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    case (step)
      //        rd  rd_addr  mul mul_src coef     acc_op  wr  wr_src  wr_dst   flow
      // wait for a sample
      5'd0:  w = '{1'b0, R_XS,    1'b0, MS_RD,  C_RBASS, A_NOP,  1'b0, WS_ACC, R_XS,    F_IDLE};
      // bass bandpass
      5'd1:  w = '{1'b0, R_XS,    1'b0, MS_RD,  C_RBASS, A_LDX,  1'b0, WS_ACC, R_XS,    F_NEXT};
      5'd2:  w = '{1'b1, R_BOUT1, 1'b1, MS_ACC, C_RBASS, A_NOP,  1'b0, WS_ACC, R_XS,    F_NEXT};
      5'd3:  w = '{1'b1, R_BOUT0, 1'b1, MS_RD,  C_BA2,   A_PROD, 1'b0, WS_ACC, R_XS,    F_NEXT};
      5'd4:  w = '{1'b1, R_BIN1,  1'b1, MS_RD,  C_BA1,   A_ADDP, 1'b1, WS_ACC, R_XS,    F_NEXT};
      5'd5:  w = '{1'b0, R_XS,    1'b0, MS_RD,  C_RBASS, A_ADDP, 1'b0, WS_ACC, R_XS,    F_NEXT};
      5'd6:  w = '{1'b1, R_BIN0,  1'b0, MS_RD,  C_RBASS, A_SUBR, 1'b0, WS_ACC, R_XS,    F_NEXT};
      5'd7:  w = '{1'b1, R_BOUT0, 1'b0, MS_RD,  C_RBASS, A_NOP,  1'b1, WS_RD,  R_BIN1,  F_NEXT};
      5'd8:  w = '{1'b1, R_XS,    1'b0, MS_RD,  C_RBASS, A_NOP,  1'b1, WS_RD,  R_BOUT1, F_NEXT};
      5'd9:  w = '{1'b0, R_XS,    1'b0, MS_RD,  C_RBASS, A_ABS,  1'b1, WS_ACC, R_BOUT0, F_NEXT};
      // rectified envelope lowpass
      5'd10: w = '{1'b1, R_EOUT,  1'b1, MS_ACC, C_RENV,  A_NOP,  1'b1, WS_RD,  R_BIN0,  F_NEXT};
      5'd11: w = '{1'b1, R_EIN,   1'b1, MS_RD,  C_EA1,   A_PROD, 1'b0, WS_ACC, R_XS,    F_NEXT};
      5'd12: w = '{1'b0, R_XS,    1'b0, MS_RD,  C_RBASS, A_ADDP, 1'b1, WS_ACC, R_EIN,   F_NEXT};
      5'd13: w = '{1'b0, R_XS,    1'b0, MS_RD,  C_RBASS, A_ADDR, 1'b0, WS_ACC, R_XS,    F_NEXT};
      5'd14: w = '{1'b0, R_XS,    1'b0, MS_RD,  C_RBASS, A_NOP,  1'b1, WS_ACC, R_EOUT,  F_DECIM};
      // decimated beat bandpass
      5'd15: w = '{1'b1, R_TOUT1, 1'b1, MS_ACC, C_RBEAT, A_NOP,  1'b0, WS_ACC, R_XS,    F_NEXT};
      5'd16: w = '{1'b1, R_TOUT0, 1'b1, MS_RD,  C_TA2,   A_PROD, 1'b0, WS_ACC, R_XS,    F_NEXT};
      5'd17: w = '{1'b1, R_TIN1,  1'b1, MS_RD,  C_TA1,   A_ADDP, 1'b1, WS_ACC, R_XS,    F_NEXT};
      5'd18: w = '{1'b0, R_XS,    1'b0, MS_RD,  C_RBASS, A_ADDP, 1'b0, WS_ACC, R_XS,    F_NEXT};
      5'd19: w = '{1'b1, R_TIN0,  1'b0, MS_RD,  C_RBASS, A_SUBR, 1'b0, WS_ACC, R_XS,    F_NEXT};
      5'd20: w = '{1'b1, R_TOUT0, 1'b0, MS_RD,  C_RBASS, A_NOP,  1'b1, WS_RD,  R_TIN1,  F_NEXT};
      5'd21: w = '{1'b1, R_XS,    1'b0, MS_RD,  C_RBASS, A_NOP,  1'b1, WS_RD,  R_TOUT1, F_NEXT};
      5'd22: w = '{1'b0, R_XS,    1'b0, MS_RD,  C_RBASS, A_NOP,  1'b1, WS_ACC, R_TOUT0, F_FLAG};
      5'd23: w = '{1'b0, R_XS,    1'b0, MS_RD,  C_RBASS, A_NOP,  1'b1, WS_RD,  R_TIN0,  F_NEXT};
      // hand the result to the output register
      5'd24: w = '{1'b0, R_XS,    1'b0, MS_RD,  C_RBASS, A_NOP,  1'b0, WS_ACC, R_XS,    F_DONE};
      default: w = '{1'b0, R_XS,  1'b0, MS_RD,  C_RBASS, A_NOP,  1'b0, WS_ACC, R_XS,    F_DONE};
    endcase
    return w;
  endfunction

endpackage

/* rtl/abd_stream_if.sv */
// ----------------------------------------------------------------------------
// Audio beat detector stream interfaces
// Valid/ready channels for raw samples and for beat results.
// ----------------------------------------------------------------------------
interface abd_in_if;
  logic                            valid;
  logic                            ready;
  logic [abd_pkg::SAMPLE_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

interface abd_out_if;
  logic                       valid;
  logic                       ready;
  logic                       beat_level;
  logic                       beat_updated;
  logic [abd_pkg::DATA_W-1:0] beat_value;

  modport source (output valid, output beat_level, output beat_updated, output beat_value,
                  input ready);
  modport sink (input valid, input beat_level, input beat_updated, input beat_value,
                output ready);
endinterface

/* rtl/audio_beat_detector_top.sv */
// ----------------------------------------------------------------------------
// Audio beat detector
// Bass bandpass, rectified envelope and decimated beat bandpass in Q16.16,
// run by a microcoded sequencer over one shared multiplier and accumulator.
// ----------------------------------------------------------------------------
//
//  channel    dir  handshake            payload
//  sample_i   in   valid/ready          adc_sample[9:0]
//  result_o   out  valid/ready          beat_level, beat_updated, beat_value[31:0]
//  cfg_*_i    in   write enable only    cfg_idx_i[1:0], cfg_data_i[23:0]
//
//  Sequencing: a sample holds the sequencer from its transfer until its
//  result is loaded; the beat filter steps are skipped when the count
//  does not match. The 25-step program around the single 32x32 multiplier
//  and the register file with one read and one write port sets the time
//  that a sample takes.
//  Reset clears the filter history, decimation counter and beat level; the
//  registers return to threshold 0.8, offset 120, count 200.
//  A result waits in the output register; the sequencer holds on its last
//  step only while a previous result is still untaken.
//
module audio_beat_detector_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [abd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [abd_pkg::CFG_W-1:0]         cfg_data_i,
  abd_in_if.sink                            sample_i,
  abd_out_if.source                         result_o
);

  localparam int SB = abd_pkg::SAMPLE_BITS;
  localparam int FB = abd_pkg::FRAC_BITS;
  localparam int AW = abd_pkg::ACC_W;
  localparam int DW = abd_pkg::DATA_W;
  localparam int RW = abd_pkg::RND_W;

  // Configuration registers
  logic [abd_pkg::THR_W-1:0] thr_q;
  logic [abd_pkg::OFF_W-1:0] off_q;
  logic [abd_pkg::DEC_W-1:0] dec_q;

  // Sequencer
  logic [abd_pkg::STEP_W-1:0] step_q, step_d;
  abd_pkg::ucode_t            uc;

  // Datapath
  logic [SB-1:0]             sample_q;
  logic signed [AW-1:0]      acc_q, acc_d;
  logic signed [abd_pkg::PROD_W-1:0] prod_q, prod_d, prod_rnd;
  logic signed [AW-1:0]      rnd_ext;
  logic [DW-1:0]             prod_sat;
  logic signed [SB:0]        centered;
  logic [DW-1:0]             acc_sat;
  logic signed [DW-1:0]      mul_a, mul_c;
  logic [DW-1:0]             rd_q;
  logic [DW-1:0]             wr_data;

  // Register file with per-entry valid bits; an unwritten entry reads as zero
  logic [DW-1:0]             rf_mem [abd_pkg::NUM_REGS];
  logic [abd_pkg::NUM_REGS-1:0] rf_valid_q;

  // Beat state and output register
  logic [abd_pkg::DEC_W-1:0] count_q;
  logic                      flag_q, updated_q;
  logic [DW-1:0]             value_q;
  logic                      dec_match, out_load;
  logic                      out_valid_q, out_level_q, out_updated_q;
  logic [DW-1:0]             out_value_q;

  assign uc = abd_pkg::ucode_rom(step_q);

  // ---------------------------------------------------------------------------
  // Configuration writes; indexes beyond the register list are dropped
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= abd_pkg::THRESHOLD_RST;
      off_q <= abd_pkg::DC_OFFSET_RST;
      dec_q <= abd_pkg::DECIM_RST;
    end else if (cfg_we_i) begin
      case (abd_pkg::cfg_idx_e'(cfg_idx_i))
        abd_pkg::CFG_THRESHOLD: thr_q <= cfg_data_i[abd_pkg::THR_W-1:0];
        abd_pkg::CFG_DC_OFFSET: off_q <= cfg_data_i[abd_pkg::OFF_W-1:0];
        abd_pkg::CFG_DECIM:     dec_q <= cfg_data_i[abd_pkg::DEC_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath arithmetic
  // ---------------------------------------------------------------------------
  // Offset removal keeps the sign when the offset exceeds the sample.
  assign centered = $signed({1'b0, sample_q}) - $signed({1'b0, off_q[SB-1:0]});

  // Round the Q30 product to nearest, ties toward plus infinity.
  assign prod_rnd = prod_q + (abd_pkg::PROD_W'(1) <<< (abd_pkg::CQ - 1));
  assign rnd_ext  = {{(AW-RW){prod_rnd[abd_pkg::PROD_W-1]}},
                     prod_rnd[abd_pkg::PROD_W-1:abd_pkg::CQ]};
  assign prod_sat = abd_pkg::sat32(rnd_ext);

  assign acc_sat = abd_pkg::sat32(acc_q);

  // Shared multiplier: operand from the register file or the clamped accumulator
  assign mul_a  = (uc.mul_src == abd_pkg::MS_ACC) ? $signed(acc_sat) : $signed(rd_q);
  assign mul_c  = abd_pkg::coef_value(uc.coef);
  assign prod_d = mul_a * mul_c;

  always_comb begin
    acc_d = acc_q;
    case (uc.acc_op)
      abd_pkg::A_LDX:  acc_d = {{(AW-SB-1-FB){centered[SB]}}, centered, {FB{1'b0}}};
      abd_pkg::A_PROD: acc_d = {{(AW-DW){prod_sat[DW-1]}}, prod_sat};
      abd_pkg::A_ADDP: acc_d = acc_q + rnd_ext;
      abd_pkg::A_ADDR: acc_d = acc_q + {{(AW-DW){rd_q[DW-1]}}, rd_q};
      abd_pkg::A_SUBR: acc_d = acc_q - {{(AW-DW){rd_q[DW-1]}}, rd_q};
      // The clamp on use turns |most negative| into the largest positive value.
      abd_pkg::A_ABS:  acc_d = acc_q[AW-1] ? -acc_q : acc_q;
      default:         acc_d = acc_q;
    endcase
  end

  assign wr_data = (uc.wr_src == abd_pkg::WS_RD) ? rd_q : acc_sat;

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (uc.mul_en) begin
      prod_q <= prod_d;
    end
    if (sample_i.valid && sample_i.ready) begin
      sample_q <= sample_i.adc_sample;
    end
  end

  // ---------------------------------------------------------------------------
  // Register file: one write and one registered read per step
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (uc.wr_en) begin
      rf_mem[uc.wr_dst] <= wr_data;
    end
    if (uc.rd_en) begin
      rd_q <= rf_valid_q[uc.rd_addr] ? rf_mem[uc.rd_addr] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_valid_q <= '0;
    end else if (uc.wr_en) begin
      rf_valid_q[uc.wr_dst] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: advance through the program, branch on the decimation count
  // ---------------------------------------------------------------------------
  assign dec_match = (count_q == dec_q);

  always_comb begin
    step_d         = step_q;
    out_load       = 1'b0;
    sample_i.ready = 1'b0;
    case (uc.flow)
      abd_pkg::F_IDLE: begin
        sample_i.ready = 1'b1;
        if (sample_i.valid) begin
          step_d = abd_pkg::STEP_FIRST;
        end
      end
      abd_pkg::F_NEXT, abd_pkg::F_FLAG: begin
        step_d = step_q + abd_pkg::STEP_W'(1);
      end
      abd_pkg::F_DECIM: begin
        step_d = dec_match ? step_q + abd_pkg::STEP_W'(1) : abd_pkg::STEP_DONE;
      end
      abd_pkg::F_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_q || result_o.ready) begin
          out_load = 1'b1;
          step_d   = '0;
        end
      end
      default: step_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= '0;
      count_q   <= '0;
      flag_q    <= 1'b0;
      updated_q <= 1'b0;
      value_q   <= '0;
    end else begin
      step_q <= step_d;
      if (sample_i.valid && sample_i.ready) begin
        updated_q <= 1'b0;
      end
      if (uc.flow == abd_pkg::F_DECIM) begin
        if (dec_match) begin
          count_q   <= '0;
          updated_q <= 1'b1;
        end else begin
          count_q <= count_q + abd_pkg::DEC_W'(1);
        end
      end
      if (uc.flow == abd_pkg::F_FLAG) begin
        // Signed beat value against the unsigned threshold.
        flag_q  <= $signed(acc_sat) > $signed({{(DW-abd_pkg::THR_W){1'b0}}, thr_q});
        value_q <= acc_sat;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_level_q   <= flag_q;
      out_updated_q <= updated_q;
      out_value_q   <= value_q;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.beat_level   = out_level_q;
  assign result_o.beat_updated = out_updated_q;
  assign result_o.beat_value   = out_value_q;

endmodule

/* rtl/abd_checker.sv */
// ----------------------------------------------------------------------------
// Audio beat detector checker
// Port-level properties of the sample and result channels.
// ----------------------------------------------------------------------------
module abd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       out_level_i,
  input logic                       out_updated_i,
  input logic [abd_pkg::DATA_W-1:0] out_value_i
);

  // A sample transfer starts the program, so no second sample is taken next.
  a_busy_after_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("sample taken while the sequencer is busy");

  // With no sample offered the sequencer stays ready.
  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_i && !in_valid_i) |=> in_ready_i)
    else $error("sequencer left idle without a sample");

  // A stalled result keeps its payload.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable({out_level_i, out_updated_i, out_value_i})))
    else $error("stalled result changed");

endmodule

bind audio_beat_detector_top abd_checker u_abd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (sample_i.valid),
  .in_ready_i    (sample_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .out_level_i   (result_o.beat_level),
  .out_updated_i (result_o.beat_updated),
  .out_value_i   (result_o.beat_value)
);

/* bench/tb_audio_beat_detector_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio beat detector testbench
// Feeds raw samples through the stream channel and checks every result
// against a bit-exact Q16.16 predictor of the bass, envelope and beat
// filters. Directed tests cover the register extremes and corner cases.
// Random traffic follows: bass bursts, silence and noise, under three
// idling patterns.
// ----------------------------------------------------------------------------
module tb_audio_beat_detector_top;
  import abd_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int WATCHDOG_NS  = 5_000_000;
  localparam int IDLE_SETTLE  = 4;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int TAIL_CYCLES  = 40;     // longer than one sample's worst-case run

  // Q30 filter coefficients and reciprocal gains
  localparam longint K_BASS_GAIN = 117993607;
  localparam longint K_BASS_A2   = -854704936;
  localparam longint K_BASS_A1   = 1922333318;
  localparam longint K_ENV_GAIN  = 6710886;
  localparam longint K_ENV_A1    = 1060332861;
  localparam longint K_BEAT_GAIN = 153063696;
  localparam longint K_BEAT_A2   = -769858042;
  localparam longint K_BEAT_A1   = 1551949227;

  // No register sits at this index; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef logic signed [DATA_W-1:0] q16_t;

  typedef struct {
    logic              level;
    logic              updated;
    logic [DATA_W-1:0] value;
  } beat_report_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  abd_in_if  sample_if ();
  abd_out_if result_if ();

  audio_beat_detector_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .sample_i   (sample_if),
    .result_o   (result_if)
  );

  // Register copies held by the predictor
  logic [THR_W-1:0] threshold_cfg = THRESHOLD_RST;
  logic [OFF_W-1:0] dc_offset_cfg = DC_OFFSET_RST;
  logic [DEC_W-1:0] decim_cfg     = DECIM_RST;

  // Filter history, decimation counter and held level
  q16_t             bass_x1 = '0, bass_x2 = '0, bass_y1 = '0, bass_y2 = '0;
  q16_t             env_x1 = '0, env_y1 = '0;
  q16_t             beat_x1 = '0, beat_x2 = '0, beat_y1 = '0, beat_y2 = '0;
  logic [DEC_W-1:0] decim_ctr = '0;
  logic             beat_flag = 1'b0;

  beat_report_t beat_reports_q[$];
  int unsigned  fail_count = 0;

  // Idle and stall rates in percent of cycles
  int unsigned send_idle_pct = 24;
  int unsigned recv_stall_pct = 82;

  // --------------------------------------------------------------------------
  // Fixed-point predictor
  // --------------------------------------------------------------------------

  // Multiply by a Q30 constant, round half up
  function automatic longint q30_mul(input q16_t a, input longint c);
    longint prod;
    prod = longint'(a) * c;
    return (prod + 64'sd536870912) >>> CQ;
  endfunction

  function automatic q16_t sat_q16(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[DATA_W-1:0];
  endfunction

  // Advance the filter chain by one sample and form the result it yields
  task automatic predict_beat(input logic [SAMPLE_BITS-1:0] smp, output beat_report_t r);
    longint centered;
    q16_t   xq, xs, y, mag, env;
    logic   stepped;
    centered = longint'(smp) - longint'(dc_offset_cfg);
    xq = sat_q16(centered * (64'sd1 <<< FRAC_BITS));
    stepped = 1'b0;

    xs = sat_q16(q30_mul(xq, K_BASS_GAIN));
    y  = sat_q16(longint'(xs) - longint'(bass_x2) + q30_mul(bass_y2, K_BASS_A2)
                 + q30_mul(bass_y1, K_BASS_A1));
    bass_x2 = bass_x1;
    bass_x1 = xs;
    bass_y2 = bass_y1;
    bass_y1 = y;

    mag = (y < 0) ? sat_q16(-longint'(y)) : y;
    xs  = sat_q16(q30_mul(mag, K_ENV_GAIN));
    env = sat_q16(longint'(xs) + longint'(env_x1) + q30_mul(env_y1, K_ENV_A1));
    env_x1 = xs;
    env_y1 = env;

    if (decim_ctr == decim_cfg) begin
      xs = sat_q16(q30_mul(env, K_BEAT_GAIN));
      y  = sat_q16(longint'(xs) - longint'(beat_x2) + q30_mul(beat_y2, K_BEAT_A2)
                   + q30_mul(beat_y1, K_BEAT_A1));
      beat_x2 = beat_x1;
      beat_x1 = xs;
      beat_y2 = beat_y1;
      beat_y1 = y;
      // signed value against unsigned trip point
      beat_flag = longint'(y) > longint'(threshold_cfg);
      decim_ctr = '0;
      stepped = 1'b1;
    end else begin
      decim_ctr = decim_ctr + 1'b1;
    end

    r.level   = beat_flag;
    r.updated = stepped;
    r.value   = beat_y1;
  endtask

  // --------------------------------------------------------------------------
  // Clock, reset and watchdog
  // --------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #WATCHDOG_NS;
    $display("tb_audio_beat_detector_top: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random back-pressure and the checker
  // --------------------------------------------------------------------------

  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare every transfer on the result channel with the oldest prediction
  always @(posedge clk) begin : check_results
    beat_report_t want;
    if (rst_n && result_if.valid && result_if.ready) begin
      if (beat_reports_q.size() == 0) begin
        $error("result with nothing pending: level=%0b updated=%0b value=%0d",
               result_if.beat_level, result_if.beat_updated, $signed(result_if.beat_value));
        fail_count++;
      end else begin
        want = beat_reports_q.pop_front();
        if (result_if.beat_level !== want.level) begin
          $error("beat_level: expected %0b, got %0b", want.level, result_if.beat_level);
          fail_count++;
        end
        if (result_if.beat_updated !== want.updated) begin
          $error("beat_updated: expected %0b, got %0b", want.updated, result_if.beat_updated);
          fail_count++;
        end
        if (result_if.beat_value !== want.value) begin
          $error("beat_value: expected %0d, got %0d",
                 $signed(want.value), $signed(result_if.beat_value));
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------

  // Offer one sample; on its transfer, predict and queue the result. Valid
  // stays high across back-to-back samples and drops only for an idle gap.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp);
    beat_report_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      sample_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    sample_if.valid      <= 1'b1;
    sample_if.adc_sample <= smp;
    do @(posedge clk); while (!sample_if.ready);
    predict_beat(smp, r);
    beat_reports_q.push_back(r);
  endtask

  // Hold the sender until every pending result has been taken
  task automatic wait_idle();
    sample_if.valid <= 1'b0;
    while (beat_reports_q.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  // Write one register; call only with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_THRESHOLD: threshold_cfg = data[THR_W-1:0];
      CFG_DC_OFFSET: dc_offset_cfg = data[OFF_W-1:0];
      CFG_DECIM:     decim_cfg     = data[DEC_W-1:0];
      default: ;
    endcase
  endtask

  // Set the decimation count. If the counter already sits above the new
  // count, first match the count to the counter and push one sample so the
  // counter restarts from zero instead of waiting for a full wrap.
  task automatic set_decimation(input logic [CFG_W-1:0] data);
    if (decim_ctr > data[DEC_W-1:0]) begin
      write_reg(CFG_DECIM, CFG_W'(decim_ctr));
      send_sample(SAMPLE_BITS'($urandom));
      wait_idle();
    end
    write_reg(CFG_DECIM, data);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // One musical phrase: a square or saw bass burst, silence, or noise
  task automatic play_phrase(input int room, output int played);
    int kind, len, amp, period, center, lvl;
    logic [SAMPLE_BITS-1:0] smp;
    kind   = $urandom_range(9);
    amp    = ($urandom_range(7) == 0) ? 1023 : $urandom_range(511);
    period = $urandom_range(4, 80);
    center = ($urandom_range(2) == 0) ? $urandom_range(1023) : dc_offset_cfg;
    len    = (kind == 9) ? $urandom_range(1, 8) : $urandom_range(8, 60);
    if (len > room) len = room;
    for (int i = 0; i < len; i++) begin
      if (kind < 4) begin
        lvl = ((i % period) < period / 2) ? center + amp : center - amp;
      end else if (kind < 7) begin
        lvl = center - amp + (2 * amp * (i % period)) / period;
      end else if (kind < 9) begin
        lvl = dc_offset_cfg;
      end else begin
        lvl = $urandom_range(1023);
      end
      smp = (lvl < 0) ? '0 : (lvl > 1023) ? '1 : SAMPLE_BITS'(lvl);
      send_sample(smp);
    end
    played = len;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values: count 200 keeps the beat filter idle, value reads zero
  task automatic test_reset_state();
    send_sample(SAMPLE_BITS'(120));
    send_sample('0);
    send_sample('1);
    wait_idle();
  endtask

  // Offset above sample gives a negative centered value; upper data bits drop
  task automatic test_offset_extremes();
    write_reg(CFG_DC_OFFSET, 24'h00_03FF);
    send_sample('0);
    send_sample('1);
    wait_idle();
    write_reg(CFG_DC_OFFSET, 24'hAB_5C00);
    send_sample('1);
    send_sample('0);
    wait_idle();
  endtask

  // Count of zero runs the beat filter on every sample; sweep the threshold
  task automatic test_every_sample();
    set_decimation(24'hA5_0000);
    write_reg(CFG_THRESHOLD, 24'h00_0000);
    send_sample('1);
    send_sample('0);
    send_sample('1);
    send_sample('0);
    wait_idle();
    write_reg(CFG_THRESHOLD, 24'hFF_FFFF);
    send_sample('1);
    send_sample('1);
    wait_idle();
    write_reg(CFG_THRESHOLD, 24'h80_0000);
    send_sample('0);
    wait_idle();
    write_reg(CFG_THRESHOLD, 24'h00_0001);
    send_sample(SAMPLE_BITS'(10'h2AA));
    send_sample(SAMPLE_BITS'(10'h155));
    wait_idle();
  endtask

  // Drop the count below the running counter: the counter must run past it
  task automatic test_count_passed();
    set_decimation(24'd3);
    send_sample(SAMPLE_BITS'(700));
    send_sample(SAMPLE_BITS'(20));
    wait_idle();
    write_reg(CFG_DECIM, 24'd1);
    repeat (5) send_sample(SAMPLE_BITS'($urandom));
    wait_idle();
    write_reg(CFG_DECIM, 24'h00_FFFF);
    send_sample(SAMPLE_BITS'($urandom));
    wait_idle();
    set_decimation(24'd4);
    repeat (5) send_sample(SAMPLE_BITS'($urandom));
    wait_idle();
  endtask

  // A write to the spare index must leave every register alone
  task automatic test_unused_index();
    write_reg(CFG_IDX_UNUSED, 24'hFF_FFFF);
    send_sample('1);
    send_sample('0);
    wait_idle();
  endtask

  // Random settings per segment, each segment a string of phrases
  task automatic test_random_traffic(input int n_items);
    int sent, seg_end, played, pick;
    logic [THR_W-1:0] thr;
    logic [OFF_W-1:0] off;
    logic [DEC_W-1:0] dec;
    sent = 0;
    while (sent < n_items) begin
      wait_idle();
      case ($urandom_range(7))
        0:       thr = '0;
        1:       thr = THRESHOLD_RST;
        2:       thr = 24'h80_0000;
        3:       thr = '1;
        4:       thr = THR_W'($urandom);
        default: thr = THR_W'($urandom_range(1 << 22));
      endcase
      pick = $urandom_range(5);
      off  = (pick == 0) ? '0 : (pick == 1) ? '1 : OFF_W'($urandom);
      pick = $urandom_range(19);
      dec  = (pick == 0) ? '1 : (pick < 3) ? DEC_W'($urandom_range(8, 40))
                                           : DEC_W'($urandom_range(7));
      write_reg(CFG_THRESHOLD, thr);
      write_reg(CFG_DC_OFFSET, {14'($urandom), off});
      set_decimation({8'($urandom), dec});
      seg_end = sent + $urandom_range(24, 64);
      if (seg_end > n_items) seg_end = n_items;
      while (sent < seg_end) begin
        play_phrase(seg_end - sent, played);
        sent += played;
      end
    end
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  // Rectifying full-scale negative is out of reach here: with 10-bit samples
  // the bass output stays far below 2^31, so the predictor alone covers it.
  initial begin
    int spin;
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_idx              <= CFG_THRESHOLD;
    cfg_data             <= '0;
    sample_if.valid      <= 1'b0;
    sample_if.adc_sample <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_offset_extremes();
    test_every_sample();
    test_count_passed();
    test_unused_index();

    set_idling(24, 82);
    test_random_traffic(320);
    set_idling(82, 24);
    test_random_traffic(315);
    set_idling(0, 0);
    test_random_traffic(315);

    // Drain, then watch a while longer for stray transfers
    sample_if.valid <= 1'b0;
    for (spin = 0; spin < DRAIN_LIMIT && beat_reports_q.size() != 0; spin++) @(posedge clk);
    if (beat_reports_q.size() != 0) begin
      $error("%0d results never arrived", beat_reports_q.size());
      fail_count++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb_audio_beat_detector_top: done, clean");
    end else begin
      $display("tb_audio_beat_detector_top: done, errors");
    end
    $finish;
  end

endmodule
